FILE: hw/rtl/lbf_pkg.sv
// shared types and constants for the led breathing fader
`timescale 1ns / 1ps
`default_nettype none

package lbf_pkg;

  // full-scale duty and pause length in ticks
  localparam logic [9:0] FULL_SCALE  = 10'd1000;
  localparam logic [7:0] PAUSE_TICKS = 8'd200;

  // ramp segment breakpoints on the pre-step level
  localparam logic [9:0] BP_100 = 10'd100;
  localparam logic [9:0] BP_200 = 10'd200;
  localparam logic [9:0] BP_300 = 10'd300;
  localparam logic [9:0] BP_700 = 10'd700;

  // dwell lengths per step
  localparam logic [7:0] DWELL_7 = 8'd7;
  localparam logic [7:0] DWELL_5 = 8'd5;
  localparam logic [7:0] DWELL_3 = 8'd3;
  localparam logic [7:0] DWELL_1 = 8'd1;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_FADE_ON  = 3'd1;
  localparam logic [2:0] MODE_FADE_OFF = 3'd2;
  localparam logic [2:0] MODE_FLASH    = 3'd3;
  localparam logic [2:0] MODE_STOP     = 3'd4;
  localparam logic [2:0] MODE_SET      = 3'd5;

  // input beat
  typedef struct packed {
    logic [2:0] mode;
    logic [9:0] start_level;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic [9:0] duty;
    logic       lit;
    logic       busy_res;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/led_breathing_fader.sv
// led breathing fader: duty ramps, flash sequencer and result buffering
//
// Usage: every beat on the cmd channel is either a timer tick or a command
// (fade on, fade off, flash, stop flash, set level). Each accepted cmd beat
// produces exactly one res beat carrying the duty level after that beat,
// the lit flag and a busy flag for a running ramp, pause or flash sequence.
// Both channels use valid/ready; a beat moves when valid and ready are high
// at a rising edge of clk.
// A result is registered into res, or into the skid register while res stalls.
// Throughput: one cmd beat per cycle while cmd_ready is high; each fader state
// update is a single registered step, so back-to-back ticks run at full rate.
// Stall: a two-entry output buffer (result register plus skid register)
// lets one more beat in while a result waits; cmd_ready drops only once
// both entries are full, and returns in the cycle after res is taken.
// Reset: rst (synchronous, active high) returns the fader to level 0, unlit,
// idle with no flash, and empties the output buffer.
`timescale 1ns / 1ps
`default_nettype none

module led_breathing_fader (
  input  wire          clk,
  input  wire          rst,
  input  wire          cmd_valid,
  output logic         cmd_ready,
  input  wire lbf_pkg::cmd_t cmd,
  output logic         res_valid,
  input  wire          res_ready,
  output lbf_pkg::res_t res
);

  // fader phase codes
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_UP         = 3'd1;
  localparam logic [2:0] PH_DOWN       = 3'd2;
  localparam logic [2:0] PH_PAUSE      = 3'd3;
  localparam logic [2:0] PH_DOWN_FIRST = 3'd4;

  typedef struct packed {
    logic [9:0] level;
    logic [7:0] dwell;
    logic [2:0] phase;
    logic       lit;
    logic       flash;
    logic       stop;
  } fade_st_t;

  fade_st_t      st;
  fade_st_t      st_next;
  lbf_pkg::res_t res_next;
  lbf_pkg::res_t skid;
  logic          skid_valid;
  logic          cmd_fire;
  logic [9:0]    start_sat;

  // dwell after an upward step, from the pre-step level
  function automatic logic [7:0] dwell_up(input logic [9:0] v);
    if (v <= lbf_pkg::BP_100)      return lbf_pkg::DWELL_7;
    else if (v <= lbf_pkg::BP_300) return lbf_pkg::DWELL_5;
    else if (v <= lbf_pkg::BP_700) return lbf_pkg::DWELL_3;
    else                           return lbf_pkg::DWELL_1;
  endfunction

  // dwell after a downward step, from the pre-step level
  function automatic logic [7:0] dwell_down(input logic [9:0] v);
    if (v <= lbf_pkg::BP_100)      return lbf_pkg::DWELL_7;
    else if (v <= lbf_pkg::BP_200) return lbf_pkg::DWELL_5;
    else if (v <= lbf_pkg::BP_300) return lbf_pkg::DWELL_3;
    else                           return lbf_pkg::DWELL_1;
  endfunction

  // end of a ramp: set lit, then idle, stop the flash or start a pause
  function automatic fade_st_t finish_ramp(input fade_st_t s, input logic up);
    fade_st_t r;
    r = s;
    r.lit = up;
    if (!r.flash) begin
      r.phase = PH_IDLE;
      r.dwell = '0;
    end else if (r.phase != PH_DOWN_FIRST && r.stop) begin
      r.flash = 1'b0;
      r.stop  = 1'b0;
      r.phase = PH_IDLE;
      r.dwell = '0;
    end else begin
      r.phase = PH_PAUSE;
      r.dwell = lbf_pkg::PAUSE_TICKS;
    end
    return r;
  endfunction

  // one ramp step from v, or finish when the end level is reached
  function automatic fade_st_t ramp_from(input fade_st_t s, input logic [9:0] v,
                                         input logic [2:0] ph);
    fade_st_t r;
    r = s;
    r.phase = ph;
    if (ph == PH_UP) begin
      if (v < lbf_pkg::FULL_SCALE) begin
        r.level = v + 10'd1;
        r.dwell = dwell_up(v);
      end else begin
        r = finish_ramp(r, 1'b1);
      end
    end else begin
      if (v != 10'd0) begin
        r.level = v - 10'd1;
        r.dwell = dwell_down(v);
      end else begin
        r = finish_ramp(r, 1'b0);
      end
    end
    return r;
  endfunction

  // handshake: room while the skid entry is free
  assign cmd_ready = !skid_valid;
  assign cmd_fire  = cmd_valid && cmd_ready;

  // start level saturates at full scale
  assign start_sat = (cmd.start_level > lbf_pkg::FULL_SCALE) ?
                     lbf_pkg::FULL_SCALE : cmd.start_level;

  // next fader state for the current beat
  always_comb begin
    st_next = st;
    case (cmd.mode)
      lbf_pkg::MODE_TICK: begin
        if (st.phase != PH_IDLE) begin
          if (st.dwell > 8'd1) begin
            st_next.dwell = st.dwell - 8'd1;
          end else begin
            case (st.phase)
              PH_PAUSE: begin
                if (st.lit) st_next = ramp_from(st, lbf_pkg::FULL_SCALE, PH_DOWN);
                else        st_next = ramp_from(st, 10'd0, PH_UP);
              end
              PH_UP:         st_next = ramp_from(st, st.level, PH_UP);
              PH_DOWN:       st_next = ramp_from(st, st.level, PH_DOWN);
              PH_DOWN_FIRST: st_next = ramp_from(st, st.level, PH_DOWN_FIRST);
              default: begin
                st_next.phase = PH_IDLE;
                st_next.dwell = '0;
              end
            endcase
          end
        end
      end
      lbf_pkg::MODE_FADE_ON: begin
        st_next.flash = 1'b0;
        st_next.stop  = 1'b0;
        st_next = ramp_from(st_next, start_sat, PH_UP);
      end
      lbf_pkg::MODE_FADE_OFF: begin
        st_next.flash = 1'b0;
        st_next.stop  = 1'b0;
        st_next = ramp_from(st_next, start_sat, PH_DOWN);
      end
      lbf_pkg::MODE_FLASH: begin
        st_next.flash = 1'b1;
        st_next.stop  = 1'b0;
        if (st.lit) begin
          st_next = ramp_from(st_next, lbf_pkg::FULL_SCALE, PH_DOWN_FIRST);
        end else begin
          st_next.phase = PH_PAUSE;
          st_next.dwell = lbf_pkg::PAUSE_TICKS;
        end
      end
      lbf_pkg::MODE_STOP: begin
        if (st.flash) st_next.stop = 1'b1;
      end
      lbf_pkg::MODE_SET: begin
        st_next.flash = 1'b0;
        st_next.stop  = 1'b0;
        st_next.phase = PH_IDLE;
        st_next.dwell = '0;
        st_next.level = start_sat;
        st_next.lit   = 1'b1;
      end
      default: st_next = st;
    endcase
  end

  // result beat from the updated state
  always_comb begin
    res_next.duty     = st_next.level;
    res_next.lit      = st_next.lit;
    res_next.busy_res = (st_next.phase != PH_IDLE);
  end

  // fader state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (cmd_fire) begin
      st <= st_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= cmd_fire;
      end
    end else if (cmd_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      if (skid_valid) res <= skid;
      else if (cmd_fire) res <= res_next;
    end else if (cmd_fire) begin
      skid <= res_next;
    end
  end

  // idle fader holds no pending dwell
  a_idle_dwell: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) |-> (st.dwell == 8'd0))
    else $error("idle phase with nonzero dwell");

  // duty never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    st.level <= lbf_pkg::FULL_SCALE)
    else $error("level above full scale");

  // a stop request only exists inside a flash sequence
  a_stop_flash: assert property (@(posedge clk) disable iff (rst)
    st.stop |-> st.flash)
    else $error("stop pending without flash");

  // the initial flash fade-down only runs with flash active
  a_first_flash: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_DOWN_FIRST) |-> st.flash)
    else $error("first flash ramp without flash");

  // skid entry is only filled behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid full with output register empty");

  // a beat taken into a stalled output fills the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && res_valid && !res_ready) |=> skid_valid)
    else $error("beat lost on stalled output");

endmodule

`default_nettype wire
